>>> sv/vfc_pkg.sv
// ----------------------------------------------------------------------------
// vfc_pkg: shared types and constants of the voxel face culler
// Item structs, store geometry, command and face codes, sequencer states.
// ----------------------------------------------------------------------------
package vfc_pkg;

  localparam int WORLD_BITS  = 5;
  localparam int WORLD_SIDE  = 1 << WORLD_BITS;
  localparam int CHUNK_BITS  = 4;
  localparam int TEX_W       = 8;
  localparam int ENTRY_W     = TEX_W + 2;
  localparam int ADDR_W      = 3 * WORLD_BITS;
  localparam int STORE_DEPTH = WORLD_SIDE * WORLD_SIDE * WORLD_SIDE;

  localparam logic [WORLD_BITS-1:0] COORD_MAX = WORLD_BITS'(WORLD_SIDE - 1);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_MESH  = 1'b1;

  typedef enum logic [2:0] {
    FACE_NX = 3'd0,
    FACE_PX = 3'd1,
    FACE_NY = 3'd2,
    FACE_PY = 3'd3,
    FACE_NZ = 3'd4,
    FACE_PZ = 3'd5
  } face_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_GATHER,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                  command;
    logic [WORLD_BITS-1:0] pos_x;
    logic [WORLD_BITS-1:0] pos_y;
    logic [WORLD_BITS-1:0] pos_z;
    logic                  chunk_x;
    logic                  chunk_y;
    logic                  chunk_z;
    logic [1:0]            detail_level;
    logic                  occludes;
    logic                  visible;
    logic [TEX_W-1:0]      texture;
  } voxel_req_t;

  typedef struct packed {
    logic [2:0]            face;
    logic [CHUNK_BITS-1:0] local_x;
    logic [CHUNK_BITS-1:0] local_y;
    logic [CHUNK_BITS-1:0] local_z;
    logic [2:0]            quad_size;
    logic                  tex_col;
    logic [TEX_W-2:0]      tex_row;
    logic                  last;
  } face_quad_t;

endpackage

>>> sv/vfc_ram.sv
// ----------------------------------------------------------------------------
// vfc_ram: generic single-port RAM
// One read or write per cycle at one address, registered read data.
// ----------------------------------------------------------------------------
module vfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> sv/voxel_face_culler.sv
// ----------------------------------------------------------------------------
// voxel_face_culler: voxel store with per-face occlusion culling
// Writes voxels to a cubic store; a visible voxel meshes to a quad per open face.
// ----------------------------------------------------------------------------
//   channel | direction | payload     | handshake
//   req     | in        | voxel_req_t | req_valid / req_ready
//   quad    | out       | face_quad_t | quad_valid / quad_ready
//
// Write item: stored through the single store port at acceptance. Mesh item:
// accepted, then store reads (centre plus six neighbours through the one
// store port), then the emitted quads in turn, held while quad is stalled.
// After reset the store is cleared one entry per cycle, all 32768 entries,
// with req_ready low. A finished quad may wait in the output register while
// the next item is accepted.
// ----------------------------------------------------------------------------
module voxel_face_culler (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  vfc_pkg::voxel_req_t req,
  output logic                quad_valid,
  input  logic                quad_ready,
  output vfc_pkg::face_quad_t quad
);
  import vfc_pkg::*;

  state_t              state, state_next;
  logic [ADDR_W-1:0]   clr_addr, clr_addr_next;
  logic [2:0]          step, step_next;
  voxel_req_t          item, item_next;
  logic                vis, vis_next;
  logic [TEX_W-1:0]    tex, tex_next;
  logic [5:0]          occl, occl_next;
  logic [5:0]          pend, pend_next;
  face_quad_t          quad_next;
  logic                quad_valid_next;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_addr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;

  logic                req_fire;
  logic                quad_load;
  logic [5:0]          pick;
  logic [2:0]          pick_face;
  logic                cap_open;

  function automatic logic [ADDR_W-1:0] nb_addr(input logic [2:0] f,
                                                input voxel_req_t r);
    logic [WORLD_BITS-1:0] x, y, z;
    x = r.pos_x;
    y = r.pos_y;
    z = r.pos_z;
    case (face_t'(f))
      FACE_NX: x = x - WORLD_BITS'(1);
      FACE_PX: x = x + WORLD_BITS'(1);
      FACE_NY: y = y - WORLD_BITS'(1);
      FACE_PY: y = y + WORLD_BITS'(1);
      FACE_NZ: z = z - WORLD_BITS'(1);
      FACE_PZ: z = z + WORLD_BITS'(1);
      default: ;
    endcase
    return {x, y, z};
  endfunction

  function automatic logic nb_inside(input logic [2:0] f, input voxel_req_t r);
    case (face_t'(f))
      FACE_NX: return r.pos_x != '0;
      FACE_PX: return r.pos_x != COORD_MAX;
      FACE_NY: return r.pos_y != '0;
      FACE_PY: return r.pos_y != COORD_MAX;
      FACE_NZ: return r.pos_z != '0;
      FACE_PZ: return r.pos_z != COORD_MAX;
      default: return 1'b0;
    endcase
  endfunction

  vfc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign req_ready = (state == ST_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign quad_load = (state == ST_EMIT) && (!quad_valid || quad_ready);
  assign pick      = pend & (~pend + 6'd1);

  always_comb begin
    pick_face = 3'd0;
    for (int i = 5; i >= 0; i--) begin
      if (pend[i]) begin
        pick_face = 3'(i);
      end
    end
  end

  assign cap_open = !(ram_rdata[0] && nb_inside(step - 3'd2, item));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_fire && req.command == CMD_MESH) begin
          state_next = ST_GATHER;
        end
      end
      ST_GATHER: begin
        if (step == 3'd7) begin
          state_next = (pend_next != '0) ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (quad_load && (pend & ~pick) == '0) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // datapath and store control
  always_comb begin
    clr_addr_next   = clr_addr;
    step_next       = step;
    item_next       = item;
    vis_next        = vis;
    tex_next        = tex;
    occl_next       = occl;
    pend_next       = pend;
    quad_next       = quad;
    quad_valid_next = quad_valid;
    ram_we          = 1'b0;
    ram_addr        = {item.pos_x, item.pos_y, item.pos_z};
    ram_wdata       = '0;

    if (quad_valid && quad_ready) begin
      quad_valid_next = 1'b0;
    end

    case (state)
      ST_CLEAR: begin
        ram_we        = 1'b1;
        ram_addr      = clr_addr;
        clr_addr_next = clr_addr + ADDR_W'(1);
      end
      ST_IDLE: begin
        ram_addr  = {req.pos_x, req.pos_y, req.pos_z};
        ram_wdata = {req.texture, req.visible, req.occludes};
        ram_we    = req_fire && req.command == CMD_WRITE;
        item_next = req;
        step_next = 3'd0;
      end
      ST_GATHER: begin
        step_next = step + 3'd1;
        if (step != 3'd0) begin
          ram_addr = nb_addr(step - 3'd1, item);
        end
        if (step == 3'd1) begin
          vis_next = ram_rdata[1];
          tex_next = ram_rdata[ENTRY_W-1:2];
        end
        if (step >= 3'd2) begin
          occl_next[step - 3'd2] = !cap_open;
        end
        if (step == 3'd7) begin
          pend_next = vis ? ~{!cap_open, occl[4:0]} : '0;
        end
      end
      ST_EMIT: begin
        if (quad_load) begin
          pend_next           = pend & ~pick;
          quad_valid_next     = 1'b1;
          quad_next.face      = pick_face;
          quad_next.local_x   = item.pos_x[CHUNK_BITS-1:0];
          quad_next.local_y   = item.pos_y[CHUNK_BITS-1:0];
          quad_next.local_z   = item.pos_z[CHUNK_BITS-1:0];
          quad_next.quad_size = {1'b0, item.detail_level} + 3'd1;
          quad_next.tex_col   = tex[0];
          quad_next.tex_row   = tex[TEX_W-1:1];
          quad_next.last      = (pend & ~pick) == '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      step       <= '0;
      pend       <= '0;
      quad_valid <= 1'b0;
    end else begin
      state      <= state_next;
      clr_addr   <= clr_addr_next;
      step       <= step_next;
      pend       <= pend_next;
      quad_valid <= quad_valid_next;
    end
    item <= item_next;
    vis  <= vis_next;
    tex  <= tex_next;
    occl <= occl_next;
    quad <= quad_next;
  end

  a_emit_has_faces: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> pend != '0)
    else $error("emit state with no pending face");

  a_one_face_per_load: assert property (@(posedge clk) disable iff (rst)
    quad_load |=> $countones(pend) == $countones($past(pend)) - 1)
    else $error("quad load did not retire exactly one face");

  a_last_ends_request: assert property (@(posedge clk) disable iff (rst)
    quad_load && quad_next.last |=> state == ST_IDLE && pend == '0)
    else $error("last quad issued with faces still pending");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !req_ready && !quad_valid)
    else $error("activity during store clear");

endmodule
